/* design/isc_pkg.sv */
`timescale 1ns / 1ps

package isc_pkg;

    // Field widths
    localparam int VAL_W = 32;
    localparam int CNT_W = 63;
    localparam int LEN_W = 5;

    // Default sizing
    localparam int DEF_MAX_ITEMS = 256;
    localparam int DEF_MAX_LEN   = 16;

    // Register reset value and count ceiling
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // One classified transaction handed from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    first;
        logic [LEN_W-1:0]        len;
        logic                    len_ok;
        logic                    len_zero;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } t_state;

    // Add two counts, clamp at the ceiling
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

/* design/isc_front.sv */
`timescale 1ns / 1ps

module isc_front #(
    parameter int MAX_LEN = isc_pkg::DEF_MAX_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [isc_pkg::VAL_W-1:0] i_value,
    input  logic                            i_first,
    input  logic                            i_cfg_we,
    input  logic [isc_pkg::LEN_W-1:0]       i_cfg_data,
    input  logic                            i_pop,
    output logic                            o_q_valid,
    output isc_pkg::t_item                  o_item
);

    localparam logic [6:0] MAX_LEN_W = 7'(MAX_LEN);

    logic [isc_pkg::LEN_W-1:0] r_len;
    isc_pkg::t_item            r_q [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [1:0]                r_cnt;
    isc_pkg::t_item            w_item;
    logic                      w_push;

    // Hold the target length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= isc_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // Classify the incoming transaction against the length setting
    always_comb begin
        w_item.value    = i_value;
        w_item.first    = i_first;
        w_item.len      = r_len;
        w_item.len_zero = (r_len == '0);
        w_item.len_ok   = (r_len != '0) && ({2'b00, r_len} <= MAX_LEN_W);
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_item    = r_q[r_rp];

    // Store classified transactions in a two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    // Advance queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* design/isc_back.sv */
`timescale 1ns / 1ps

module isc_back #(
    parameter int MAX_ITEMS = isc_pkg::DEF_MAX_ITEMS,
    parameter int MAX_LEN   = isc_pkg::DEF_MAX_LEN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  isc_pkg::t_item              i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [isc_pkg::CNT_W-1:0]   o_count,
    output logic                        o_full_res
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int LW = ($clog2(MAX_LEN) > 0) ? $clog2(MAX_LEN) : 1;
    localparam int CW = isc_pkg::CNT_W;
    localparam logic [6:0] MAX_LEN_W = 7'(MAX_LEN);

    // Element storage: one value and one row of counts per element
    logic signed [isc_pkg::VAL_W-1:0] r_val_mem [MAX_ITEMS];
    logic [MAX_LEN-1:0][CW-1:0]       r_cnt_mem [MAX_ITEMS];

    isc_pkg::t_state                  r_state;
    isc_pkg::t_state                  n_state;
    logic [IW-1:0]                    r_items;
    logic [CW-1:0]                    r_total;
    logic [CW-1:0]                    n_total;
    logic signed [isc_pkg::VAL_W-1:0] r_v;
    logic [MAX_LEN-1:0][CW-1:0]       r_cur;
    logic [MAX_LEN-1:0]               r_lane_en;
    logic [MAX_LEN-1:0]               n_lane_en;
    logic [AW-1:0]                    r_j;
    logic [IW-1:0]                    r_idx;
    logic                             r_full;
    logic [isc_pkg::LEN_W-1:0]        r_len;
    logic                             r_len_ok;
    logic signed [isc_pkg::VAL_W-1:0] r_rd_val;
    logic [MAX_LEN-1:0][CW-1:0]       r_rd_row;
    logic                             r_rd_vld;
    logic                             r_out_valid;
    logic [CW-1:0]                    r_out_count;
    logic                             r_out_full;

    logic [IW-1:0]                    w_idx;
    logic                             w_full;
    logic                             w_out_free;
    logic                             w_rd_en;
    logic                             w_mem_we;
    logic                             w_out_load;
    logic                             w_last;
    logic [6:0]                       w_top;
    logic [5:0]                       w_len_m1;
    logic [CW-1:0]                    w_sel;
    logic                             w_less;

    // Classify the head transaction against the current fill
    assign w_idx      = i_item.first ? '0 : r_items;
    assign w_full     = !i_item.first && (r_items == IW'(MAX_ITEMS));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_last     = (r_j == AW'(r_idx - IW'(1)));
    assign w_less     = (r_rd_val < r_v);

    // Number of lengths computed for this element
    always_comb begin
        if (i_item.len_ok) begin
            w_top = {2'b00, i_item.len};
        end else if (i_item.len_zero) begin
            w_top = 7'd1;
        end else begin
            w_top = MAX_LEN_W;
        end
        for (int l = 0; l < MAX_LEN; l++) begin
            n_lane_en[l] = (7'(l) < w_top);
        end
    end

    // Pick this element's count at the target length and fold it into the total
    assign w_len_m1 = {1'b0, r_len} - 6'd1;
    assign w_sel    = r_cur[w_len_m1[LW-1:0]];
    always_comb begin
        if (!r_full && r_len_ok) begin
            n_total = isc_pkg::sat_add(r_total, w_sel);
        end else begin
            n_total = r_total;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            isc_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (w_full || (w_idx == '0)) begin
                        n_state = isc_pkg::S_DONE;
                    end else begin
                        n_state = isc_pkg::S_WALK;
                    end
                end
            end
            isc_pkg::S_WALK: begin
                if (w_last) begin
                    n_state = isc_pkg::S_DRAIN;
                end
            end
            isc_pkg::S_DRAIN: begin
                n_state = isc_pkg::S_DONE;
            end
            isc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = isc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isc_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_pop      = 1'b0;
        w_rd_en    = 1'b0;
        w_mem_we   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            isc_pkg::S_IDLE: begin
                o_pop = i_q_valid;
            end
            isc_pkg::S_WALK: begin
                w_rd_en = 1'b1;
            end
            isc_pkg::S_DONE: begin
                w_out_load = w_out_free;
                w_mem_we   = w_out_free && !r_full;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Read one earlier element per cycle, store the new element when done
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_val <= r_val_mem[r_j];
            r_rd_row <= r_cnt_mem[r_j];
        end
        if (w_mem_we) begin
            r_val_mem[r_idx[AW-1:0]] <= r_v;
            r_cnt_mem[r_idx[AW-1:0]] <= r_cur;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isc_pkg::S_IDLE;
            r_items     <= '0;
            r_total     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (o_pop && i_item.first) begin
                r_items <= '0;
                r_total <= '0;
            end else if (w_out_load) begin
                r_total <= n_total;
                if (!r_full) begin
                    r_items <= r_idx + IW'(1);
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working element: load on pop, accumulate smaller predecessors
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_v       <= i_item.value;
            r_len     <= i_item.len;
            r_len_ok  <= i_item.len_ok;
            r_lane_en <= n_lane_en;
            r_idx     <= w_idx;
            r_full    <= w_full;
            r_j       <= '0;
            r_cur     <= (MAX_LEN*CW)'(1);
        end else begin
            if (w_rd_en) begin
                r_j <= r_j + AW'(1);
            end
            if (r_rd_vld && w_less) begin
                for (int l = 1; l < MAX_LEN; l++) begin
                    if (r_lane_en[l]) begin
                        r_cur[l] <= isc_pkg::sat_add(r_cur[l], r_rd_row[l-1]);
                    end
                end
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_count <= n_total;
            r_out_full  <= r_full;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_count    = r_out_count;
    assign o_full_res = r_out_full;

`ifndef SYNTH
    a_rd_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == isc_pkg::S_WALK))
        else $error("read data arrived without a walk step");

    a_items_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_items <= IW'(MAX_ITEMS))
        else $error("element fill beyond capacity");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isc_pkg::S_WALK) |-> (IW'(r_j) < r_idx))
        else $error("walk reads an element not yet stored");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == isc_pkg::S_DONE))
        else $error("result presented outside completion");
`endif

endmodule

/* design/increasing_subsequence_counter.sv */
`timescale 1ns / 1ps
// From accept, each transaction waits for those ahead of it in the queue, then walks the i earlier
//   stored elements (no walk when i is 0 or the sequence is full) before its result is loaded.
// The back end takes a new transaction only after the last result is loaded; the pace is set
//   by the one-element-per-cycle walk over the single read port of the element memory.
// Reset: synchronous active-low i_rst_n clears the queue, fill count, total and target length 1.

module increasing_subsequence_counter #(
    parameter int MAX_ITEMS = isc_pkg::DEF_MAX_ITEMS,
    parameter int MAX_LEN   = isc_pkg::DEF_MAX_LEN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [isc_pkg::VAL_W-1:0] i_value,
    input  logic                             i_first,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [isc_pkg::CNT_W-1:0]        o_count,
    output logic                             o_full_res,
    input  logic                             i_cfg_we,
    input  logic [isc_pkg::LEN_W-1:0]        i_cfg_data
);

    logic           w_q_valid;
    logic           w_pop;
    isc_pkg::t_item w_item;

    // Accept and classify transactions
    isc_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .i_first    (i_first),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pop      (w_pop),
        .o_q_valid  (w_q_valid),
        .o_item     (w_item)
    );

    // Walk stored elements and produce the running count
    isc_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_LEN   (MAX_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_item     (w_item),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_count    (o_count),
        .o_full_res (o_full_res)
    );

endmodule

/* sim/tb_increasing_subsequence_counter.sv */
`timescale 1ns / 1ps

module tb_increasing_subsequence_counter;

    localparam int               VAL_W       = isc_pkg::VAL_W;
    localparam int               CNT_W       = isc_pkg::CNT_W;
    localparam int               LEN_W       = isc_pkg::LEN_W;
    localparam logic [LEN_W-1:0] LEN_RESET   = isc_pkg::LEN_RESET;
    localparam logic [CNT_W-1:0] CNT_MAX     = isc_pkg::CNT_MAX;
    localparam int               N_SLOTS     = isc_pkg::DEF_MAX_ITEMS;
    localparam int               N_LENS      = isc_pkg::DEF_MAX_LEN;
    localparam int               RANDOM_GOAL = 1200;
    localparam int               MAX_WAIT    = 17;

    typedef enum {ROW_ITEM, ROW_CFG, ROW_RAMP} t_row_kind;
    typedef enum {SHAPE_WIDE, SHAPE_NARROW, SHAPE_RISE, SHAPE_FALL} t_shape;

    typedef struct {
        t_row_kind               kind;
        logic signed [VAL_W-1:0] value;
        logic                    first;
        int                      reps;
        logic                    pinned;
        logic [CNT_W-1:0]        exp_count;
        logic                    exp_full;
    } t_plan_row;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             full_res;
    } t_tally;

    // Clock, reset and block inputs, all known from time zero
    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_valid    = 1'b0;
    logic signed [VAL_W-1:0] i_value    = '0;
    logic                    i_first    = 1'b0;
    logic                    i_stall    = 1'b0;
    logic                    i_cfg_we   = 1'b0;
    logic [LEN_W-1:0]        i_cfg_data = '0;
    logic                    o_stall;
    logic                    o_valid;
    logic [CNT_W-1:0]        o_count;
    logic                    o_full_res;

    // Predictor state
    logic signed [VAL_W-1:0] seq_vals  [N_SLOTS];
    logic [CNT_W-1:0]        len_tally [N_SLOTS][N_LENS];
    int                      n_stored  = 0;
    logic [CNT_W-1:0]        run_total = '0;
    logic [LEN_W-1:0]        tgt_len   = LEN_RESET;

    // Expected totals, oldest first
    t_tally    due_totals[$];
    t_plan_row plan[$];

    // Pinned expectation travelling with the current transaction
    logic             pin_on    = 1'b0;
    logic [CNT_W-1:0] pin_count = '0;
    logic             pin_full  = 1'b0;

    // Idling control
    logic calm        = 1'b0;
    logic took_result = 1'b0;
    int   stall_left  = 0;

    // Run statistics
    int n_errors    = 0;
    int n_checked   = 0;
    int n_full      = 0;
    int n_sat       = 0;
    int n_cfg       = 0;
    int n_effective = 0;

    increasing_subsequence_counter #(
        .MAX_ITEMS(N_SLOTS),
        .MAX_LEN  (N_LENS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .i_first   (i_first),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_count   (o_count),
        .o_full_res(o_full_res),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Add two counts, clamp at the all-ones ceiling
    function automatic logic [CNT_W-1:0] add_clamped(input logic [CNT_W-1:0] a,
                                                     input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Store one element unless the sequence is full, build its per-length counts, return the running total
    function automatic t_tally tally_subsequences(input logic signed [VAL_W-1:0] v,
                                                  input logic f);
        t_tally           res;
        logic [CNT_W-1:0] cur [N_LENS];
        int               top;
        if (f) begin
            n_stored  = 0;
            run_total = '0;
        end
        if (n_stored >= N_SLOTS) begin
            res.count    = run_total;
            res.full_res = 1'b1;
            return res;
        end
        if (tgt_len >= 1 && tgt_len <= N_LENS) begin
            top = tgt_len;
        end else begin
            top = (tgt_len == 0) ? 1 : N_LENS;
        end
        for (int l = 0; l < N_LENS; l++) begin
            cur[l] = '0;
        end
        cur[0] = 1;
        // Extend every earlier strictly smaller element by one
        for (int j = 0; j < n_stored; j++) begin
            if (seq_vals[j] < v) begin
                for (int l = 1; l < top; l++) begin
                    cur[l] = add_clamped(cur[l], len_tally[j][l-1]);
                end
            end
        end
        seq_vals[n_stored] = v;
        for (int l = 0; l < N_LENS; l++) begin
            len_tally[n_stored][l] = cur[l];
        end
        if (tgt_len >= 1 && tgt_len <= N_LENS) begin
            run_total = add_clamped(run_total, cur[tgt_len-1]);
        end
        n_stored++;
        res.count    = run_total;
        res.full_res = 1'b0;
        return res;
    endfunction

    // Predict on every accepted input transaction
    always @(posedge i_clk) begin
        t_tally t;
        if (i_rst_n && i_valid && !o_stall) begin
            t = tally_subsequences(i_value, i_first);
            if (!t.full_res) begin
                n_effective++;
            end
            if (pin_on) begin
                t.count    = pin_count;
                t.full_res = pin_full;
            end
            due_totals.push_back(t);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_tally t;
        if (i_rst_n && o_valid && !i_stall) begin
            took_result = 1'b1;
            n_checked++;
            if (due_totals.size() == 0) begin
                $error("unexpected result: count %0d full_res %0b", o_count, o_full_res);
                n_errors++;
            end else begin
                t = due_totals.pop_front();
                if (o_count !== t.count) begin
                    $error("count: expected %0d, got %0d", t.count, o_count);
                    n_errors++;
                end
                if (o_full_res !== t.full_res) begin
                    $error("full_res: expected %0b, got %0b", t.full_res, o_full_res);
                    n_errors++;
                end
                if (o_full_res === 1'b1) begin
                    n_full++;
                end
                if (o_count === {CNT_W{1'b1}}) begin
                    n_sat++;
                end
            end
        end
    end

    // Hold the result side off for a random number of cycles after each result
    always @(negedge i_clk) begin
        if (took_result) begin
            stall_left  = calm ? 0 : $urandom_range(0, MAX_WAIT);
            took_result = 1'b0;
        end
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    // Present one transaction after a random gap and hold it until taken
    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic f,
                             input logic pin, input logic [CNT_W-1:0] pcnt,
                             input logic pfull);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_value   = v;
        i_first   = f;
        pin_on    = pin;
        pin_count = pcnt;
        pin_full  = pfull;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain, then write the target length while the block is idle
    task automatic write_len(input logic [LEN_W-1:0] v);
        i_valid = 1'b0;
        while (due_totals.size() != 0) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        tgt_len    = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        n_cfg++;
    endtask

    function automatic void plan_row(input t_row_kind kind, input logic signed [VAL_W-1:0] v,
                                     input logic f, input int reps, input logic pin,
                                     input logic [CNT_W-1:0] cnt, input logic full);
        t_plan_row r;
        r.kind      = kind;
        r.value     = v;
        r.first     = f;
        r.reps      = reps;
        r.pinned    = pin;
        r.exp_count = cnt;
        r.exp_full  = full;
        plan.push_back(r);
    endfunction

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic signed [VAL_W-1:0] v;
        logic signed [VAL_W-1:0] base;
        logic                    f;
        logic                    fresh;
        t_shape                  shape;
        int                      seq_len;
        int                      target;

        // Directed rows: length one after reset, then pairs, zero, out of range
        plan_row(ROW_ITEM, 0, 1'b1, 0, 1'b1, 1, 1'b0);
        plan_row(ROW_ITEM, 32'sh7FFFFFFF, 1'b0, 0, 1'b1, 2, 1'b0);
        plan_row(ROW_ITEM, 32'sh80000000, 1'b0, 0, 1'b1, 3, 1'b0);
        plan_row(ROW_CFG, 2, 1'b0, 0, 1'b0, 0, 1'b0);
        plan_row(ROW_ITEM, -5, 1'b1, 0, 1'b1, 0, 1'b0);
        // equal values do not extend
        plan_row(ROW_ITEM, -5, 1'b0, 0, 1'b1, 0, 1'b0);
        plan_row(ROW_ITEM, 3, 1'b0, 0, 1'b1, 2, 1'b0);
        plan_row(ROW_ITEM, 32'sh7FFFFFFF, 1'b0, 0, 1'b1, 5, 1'b0);
        plan_row(ROW_CFG, 0, 1'b0, 0, 1'b0, 0, 1'b0);
        plan_row(ROW_ITEM, 1, 1'b1, 0, 1'b1, 0, 1'b0);
        plan_row(ROW_ITEM, 2, 1'b0, 0, 1'b1, 0, 1'b0);
        plan_row(ROW_CFG, 31, 1'b0, 0, 1'b0, 0, 1'b0);
        plan_row(ROW_ITEM, 3, 1'b0, 0, 1'b1, 0, 1'b0);
        // change length in the middle of a sequence
        plan_row(ROW_CFG, 3, 1'b0, 0, 1'b0, 0, 1'b0);
        plan_row(ROW_ITEM, 4, 1'b0, 0, 1'b0, 0, 1'b0);
        plan_row(ROW_CFG, 16, 1'b0, 0, 1'b0, 0, 1'b0);
        plan_row(ROW_ITEM, 9, 1'b1, 0, 1'b1, 0, 1'b0);
        // fill to capacity with a rising run, counts saturate on the way
        plan_row(ROW_RAMP, -100, 1'b1, N_SLOTS, 1'b0, 0, 1'b0);
        plan_row(ROW_ITEM, 0, 1'b0, 0, 1'b1, CNT_MAX, 1'b1);
        plan_row(ROW_ITEM, 32'sh80000000, 1'b0, 0, 1'b1, CNT_MAX, 1'b1);
        plan_row(ROW_ITEM, 5, 1'b1, 0, 1'b1, 0, 1'b0);
        plan_row(ROW_CFG, 1, 1'b0, 0, 1'b0, 0, 1'b0);
        plan_row(ROW_ITEM, 7, 1'b1, 0, 1'b1, 1, 1'b0);

        // Hold reset, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_CFG: begin
                    write_len(plan[r].value[LEN_W-1:0]);
                end
                ROW_ITEM: begin
                    send_item(plan[r].value, plan[r].first, plan[r].pinned,
                              plan[r].exp_count, plan[r].exp_full);
                end
                ROW_RAMP: begin
                    for (int k = 0; k < plan[r].reps; k++) begin
                        send_item(plan[r].value + k, plan[r].first && k == 0, 1'b0, '0, 1'b0);
                    end
                end
                default: ;
            endcase
        end

        // Random sequences: mostly fresh, some continued under a new length
        target = n_effective + RANDOM_GOAL;
        while (n_effective < target) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_len(1);
                    1:       write_len(16);
                    2:       write_len(LEN_W'($urandom_range(17, 31)));
                    3:       write_len(0);
                    default: write_len(LEN_W'($urandom_range(1, 16)));
                endcase
            end
            seq_len = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 270)
                                                   : $urandom_range(1, 30);
            fresh = ($urandom_range(0, 4) != 0);
            shape = t_shape'($urandom_range(0, 3));
            base  = int'($urandom_range(0, 2000)) - 1000;
            for (int k = 0; k < seq_len; k++) begin
                case (shape)
                    SHAPE_WIDE:   v = $urandom;
                    SHAPE_NARROW: v = int'($urandom_range(0, 12)) - 6;
                    SHAPE_RISE: begin
                        base = base + int'($urandom_range(0, 3));
                        v    = ($urandom_range(0, 9) == 0) ? $urandom : base;
                    end
                    default: begin
                        base = base - int'($urandom_range(0, 3));
                        v    = base;
                    end
                endcase
                // break a sequence now and then
                f = (k == 0 && fresh) || ($urandom_range(0, 49) == 0);
                send_item(v, f, 1'b0, '0, 1'b0);
            end
        end

        // Drain and let the pipeline settle
        i_valid = 1'b0;
        calm    = 1'b0;
        while (due_totals.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);

        $display("Checked %0d results over %0d length writes", n_checked, n_cfg);
        $display("Capacity hits %0d, saturated totals %0d", n_full, n_sat);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* increasing_subsequence_counter.f */
design/isc_pkg.sv
design/isc_front.sv
design/isc_back.sv
design/increasing_subsequence_counter.sv
sim/tb_increasing_subsequence_counter.sv
